FILE: hdl/rasp_pkg.sv
// ----------------------------------------------------------------------------
// rasp_pkg
// Widths, constants, flag bundle and arctangent table shared by the aspect
// pipeline.
// ----------------------------------------------------------------------------
package rasp_pkg;

  localparam int unsigned ELEV_W    = 32;  // one elevation sample
  localparam int unsigned SPC_W     = 32;  // spacing, Q16.16
  localparam int unsigned NUM_W     = 35;  // weighted difference, signed
  localparam int unsigned LO_W      = 32;  // low slice of |num| for the multiplier
  localparam int unsigned HI_W      = NUM_W - LO_W;
  localparam int unsigned PLO_W     = LO_W + SPC_W;
  localparam int unsigned PHI_W     = HI_W + SPC_W;
  localparam int unsigned PROD_W    = NUM_W + SPC_W;
  localparam int unsigned NORM_W    = 40;  // CORDIC operand after normalizing
  localparam int unsigned SH_W      = 5;   // normalizing shift, 0..PROD_W-NORM_W
  localparam int unsigned CX_W      = 43;  // CORDIC x/y datapath, signed
  localparam int unsigned ANG_W     = 25;  // angle, degrees Q.16
  localparam int unsigned DEG_W     = 16;  // aspect, degrees Q9.7
  localparam int unsigned RND_W     = ANG_W + 1;
  localparam int unsigned RND_SH    = 9;   // Q.16 -> Q.7
  localparam int unsigned CORDIC_MAX = 24;
  localparam int unsigned IN_W      = 8 * ELEV_W + SPC_W;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_UP_FLAG    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NS_SPACING = 1'b1;

  localparam logic [SPC_W-1:0] NS_RESET  = 32'd65536;
  localparam logic [SPC_W-1:0] SPC_ONE   = 32'd1;

  localparam logic [ANG_W-1:0] ANG_ZERO  = '0;
  localparam logic [ANG_W-1:0] ANG_90    = 25'd5898240;
  localparam logic [ANG_W-1:0] ANG_180   = 25'd11796480;
  localparam logic [ANG_W-1:0] ANG_360   = 25'd23592960;
  localparam logic [RND_W-1:0] RND_HALF  = 26'd256;

  localparam logic [DEG_W-1:0] DEG_ZERO  = '0;
  localparam logic [DEG_W-1:0] DEG_90    = 16'd11520;
  localparam logic [DEG_W-1:0] DEG_270   = 16'd34560;
  localparam logic [DEG_W:0]   DEG_WRAP  = 17'd46080;

  typedef struct packed {
    logic y_zero;
    logic y_neg;
    logic x_zero;
    logic x_neg;
    logic up;
  } rasp_flags_t;

  function automatic logic signed [NUM_W-1:0] sext_elev(input logic [ELEV_W-1:0] v);
    return {{(NUM_W-ELEV_W){v[ELEV_W-1]}}, v};
  endfunction

  // atan(2^-i) in degrees, Q.16, rounded
  function automatic logic [ANG_W-1:0] atan_step(input int unsigned i);
    logic [ANG_W-1:0] r;
    case (i)
      0:       r = 25'd2949120;
      1:       r = 25'd1740967;
      2:       r = 25'd919879;
      3:       r = 25'd466945;
      4:       r = 25'd234379;
      5:       r = 25'd117304;
      6:       r = 25'd58666;
      7:       r = 25'd29335;
      8:       r = 25'd14668;
      9:       r = 25'd7334;
      10:      r = 25'd3667;
      11:      r = 25'd1833;
      12:      r = 25'd917;
      13:      r = 25'd458;
      14:      r = 25'd229;
      15:      r = 25'd115;
      16:      r = 25'd57;
      17:      r = 25'd29;
      18:      r = 25'd14;
      19:      r = 25'd7;
      20:      r = 25'd4;
      21:      r = 25'd2;
      22:      r = 25'd1;
      default: r = 25'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/rasp_slope.sv
// ----------------------------------------------------------------------------
// rasp_slope
// Two stages: Horn weighted differences, then magnitudes and sign flags.
// ----------------------------------------------------------------------------
module rasp_slope
  import rasp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [IN_W-1:0]          in_data_i,
  input  logic [SPC_W-1:0]         ns_i,
  input  logic                     up_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [NUM_W-1:0]         ax_o,
  output logic [NUM_W-1:0]         ay_o,
  output logic [SPC_W-1:0]         ew_o,
  output logic [SPC_W-1:0]         ns_o,
  output rasp_flags_t              flags_o
);

  logic signed [NUM_W-1:0] nw, nm, ne, cw, ce, sw, sm, se;
  logic signed [NUM_W-1:0] xnum_d, ynum_d, xnum_q, ynum_q;
  logic [SPC_W-1:0]        ew_raw, ew1_d, ew1_q, ns1_d, ns1_q;
  logic                    up1_q;
  logic                    v1_q, v2_q, rdy1, rdy2;
  logic [NUM_W-1:0]        ax_d, ay_d, ax_q, ay_q;
  logic [SPC_W-1:0]        ew2_q, ns2_q;
  rasp_flags_t             fl_d, fl_q;

  assign nw     = sext_elev(in_data_i[0*ELEV_W +: ELEV_W]);
  assign nm     = sext_elev(in_data_i[1*ELEV_W +: ELEV_W]);
  assign ne     = sext_elev(in_data_i[2*ELEV_W +: ELEV_W]);
  assign cw     = sext_elev(in_data_i[3*ELEV_W +: ELEV_W]);
  assign ce     = sext_elev(in_data_i[4*ELEV_W +: ELEV_W]);
  assign sw     = sext_elev(in_data_i[5*ELEV_W +: ELEV_W]);
  assign sm     = sext_elev(in_data_i[6*ELEV_W +: ELEV_W]);
  assign se     = sext_elev(in_data_i[7*ELEV_W +: ELEV_W]);
  assign ew_raw = in_data_i[8*ELEV_W +: SPC_W];

  assign xnum_d = (nw + (cw <<< 1) + sw) - (ne + (ce <<< 1) + se);
  assign ynum_d = (sw + (sm <<< 1) + se) - (nw + (nm <<< 1) + ne);
  // zero spacing acts as the smallest step
  assign ew1_d  = (ew_raw == '0) ? SPC_ONE : ew_raw;
  assign ns1_d  = (ns_i == '0) ? SPC_ONE : ns_i;

  assign ax_d = xnum_q[NUM_W-1] ? NUM_W'(-xnum_q) : NUM_W'(xnum_q);
  assign ay_d = ynum_q[NUM_W-1] ? NUM_W'(-ynum_q) : NUM_W'(ynum_q);
  always_comb begin
    fl_d.y_zero = (ynum_q == '0);
    fl_d.y_neg  = ynum_q[NUM_W-1];
    fl_d.x_zero = (xnum_q == '0);
    fl_d.x_neg  = xnum_q[NUM_W-1];
    fl_d.up     = up1_q;
  end

  assign rdy2       = ~v2_q | out_ready_i;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      xnum_q <= xnum_d;
      ynum_q <= ynum_d;
      ew1_q  <= ew1_d;
      ns1_q  <= ns1_d;
      up1_q  <= up_i;
    end
    if (rdy2 && v1_q) begin
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      ew2_q <= ew1_q;
      ns2_q <= ns1_q;
      fl_q  <= fl_d;
    end
  end

  assign out_valid_o = v2_q;
  assign ax_o        = ax_q;
  assign ay_o        = ay_q;
  assign ew_o        = ew2_q;
  assign ns_o        = ns2_q;
  assign flags_o     = fl_q;

endmodule

FILE: hdl/rasp_mul.sv
// ----------------------------------------------------------------------------
// rasp_mul
// Cross products |x|*ns and |y|*ew in split partial products, then a common
// right shift that brings the larger one down to NORM_W bits.
// ----------------------------------------------------------------------------
module rasp_mul
  import rasp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [NUM_W-1:0]    ax_i,
  input  logic [NUM_W-1:0]    ay_i,
  input  logic [SPC_W-1:0]    ew_i,
  input  logic [SPC_W-1:0]    ns_i,
  input  rasp_flags_t         flags_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [NORM_W-1:0]   px_o,
  output logic [NORM_W-1:0]   py_o,
  output rasp_flags_t         flags_o
);

  logic               v1_q, v2_q, v3_q, v4_q;
  logic               rdy1, rdy2, rdy3, rdy4;
  logic [PLO_W-1:0]   pxl_q, pyl_q;
  logic [PHI_W-1:0]   pxh_q, pyh_q;
  logic [PROD_W-1:0]  px2_d, py2_d, px2_q, py2_q, px3_q, py3_q, por;
  logic [SH_W-1:0]    sh_d, sh_q;
  logic [NORM_W-1:0]  px4_q, py4_q;
  rasp_flags_t        f1_q, f2_q, f3_q, f4_q;

  assign px2_d = PROD_W'(pxl_q) + {pxh_q, {LO_W{1'b0}}};
  assign py2_d = PROD_W'(pyl_q) + {pyh_q, {LO_W{1'b0}}};

  // shift = bit length of the larger product minus NORM_W, floored at 0
  assign por = px2_q | py2_q;
  always_comb begin
    sh_d = '0;
    for (int k = 0; k < int'(PROD_W - NORM_W); k++) begin
      if (por[NORM_W + k]) sh_d = SH_W'(k + 1);
    end
  end

  assign rdy4       = ~v4_q | out_ready_i;
  assign rdy3       = ~v3_q | rdy4;
  assign rdy2       = ~v2_q | rdy3;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      pxl_q <= PLO_W'(ax_i[LO_W-1:0]) * PLO_W'(ns_i);
      pxh_q <= PHI_W'(ax_i[NUM_W-1:LO_W]) * PHI_W'(ns_i);
      pyl_q <= PLO_W'(ay_i[LO_W-1:0]) * PLO_W'(ew_i);
      pyh_q <= PHI_W'(ay_i[NUM_W-1:LO_W]) * PHI_W'(ew_i);
      f1_q  <= flags_i;
    end
    if (rdy2 && v1_q) begin
      px2_q <= px2_d;
      py2_q <= py2_d;
      f2_q  <= f1_q;
    end
    if (rdy3 && v2_q) begin
      px3_q <= px2_q;
      py3_q <= py2_q;
      sh_q  <= sh_d;
      f3_q  <= f2_q;
    end
    if (rdy4 && v3_q) begin
      px4_q <= NORM_W'(px3_q >> sh_q);
      py4_q <= NORM_W'(py3_q >> sh_q);
      f4_q  <= f3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign px_o        = px4_q;
  assign py_o        = py4_q;
  assign flags_o     = f4_q;

endmodule

FILE: hdl/rasp_cordic.sv
// ----------------------------------------------------------------------------
// rasp_cordic
// Vectoring CORDIC, one micro-rotation per register stage. Drives y toward
// zero and accumulates the first-quadrant angle atan(px/py) in degrees Q.16.
// ----------------------------------------------------------------------------
module rasp_cordic
  import rasp_pkg::*;
#(
  parameter int unsigned STEPS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [NORM_W-1:0]        px_i,
  input  logic [NORM_W-1:0]        py_i,
  input  rasp_flags_t              flags_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ANG_W-1:0]  z_o,
  output rasp_flags_t              flags_o
);

  logic signed [CX_W-1:0]  x_q [0:STEPS-1];
  logic signed [CX_W-1:0]  y_q [0:STEPS-1];
  logic signed [ANG_W-1:0] z_q [0:STEPS-1];
  rasp_flags_t             f_q [0:STEPS-1];
  logic signed [CX_W-1:0]  x_d [0:STEPS-1];
  logic signed [CX_W-1:0]  y_d [0:STEPS-1];
  logic signed [ANG_W-1:0] z_d [0:STEPS-1];
  rasp_flags_t             f_d [0:STEPS-1];
  logic [STEPS-1:0]        v_q, vin, rdy;
  logic                    nxt;

  // ready chain, last stage first
  always_comb begin
    nxt = out_ready_i;
    for (int i = STEPS - 1; i >= 0; i--) begin
      rdy[i] = ~v_q[i] | nxt;
      nxt    = rdy[i];
    end
  end
  assign in_ready_o = rdy[0];

  always_comb begin
    logic signed [CX_W-1:0]  xi, yi;
    logic signed [ANG_W-1:0] zi;
    for (int i = 0; i < int'(STEPS); i++) begin
      if (i == 0) begin
        xi     = {{(CX_W-NORM_W){1'b0}}, py_i};
        yi     = {{(CX_W-NORM_W){1'b0}}, px_i};
        zi     = '0;
        f_d[i] = flags_i;
        vin[i] = in_valid_i;
      end else begin
        xi     = x_q[i-1];
        yi     = y_q[i-1];
        zi     = z_q[i-1];
        f_d[i] = f_q[i-1];
        vin[i] = v_q[i-1];
      end
      // x never goes negative, so its shift is a plain one
      if (!yi[CX_W-1]) begin
        x_d[i] = xi + (yi >>> i);
        y_d[i] = yi - (xi >>> i);
        z_d[i] = zi + signed'(atan_step(i));
      end else begin
        x_d[i] = xi - (yi >>> i);
        y_d[i] = yi + (xi >>> i);
        z_d[i] = zi - signed'(atan_step(i));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < int'(STEPS); i++) begin
        if (rdy[i]) v_q[i] <= vin[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(STEPS); i++) begin
      if (rdy[i] && vin[i]) begin
        x_q[i] <= x_d[i];
        y_q[i] <= y_d[i];
        z_q[i] <= z_d[i];
        f_q[i] <= f_d[i];
      end
    end
  end

  assign out_valid_o = v_q[STEPS-1];
  assign z_o         = z_q[STEPS-1];
  assign flags_o     = f_q[STEPS-1];

endmodule

FILE: hdl/rasp_out.sv
// ----------------------------------------------------------------------------
// rasp_out
// Clamp and quadrant fold of the CORDIC angle, rounding to Q9.7 and the
// zero-slope special cases. The last stage is the output register.
// ----------------------------------------------------------------------------
module rasp_out
  import rasp_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [ANG_W-1:0]  z_i,
  input  rasp_flags_t              flags_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [DEG_W-1:0]         deg_o,
  output logic                     undef_o
);

  logic              v1_q, v2_q, rdy1, rdy2;
  logic [ANG_W-1:0]  t, ang_d, ang_q;
  logic [RND_W-1:0]  rsum;
  logic [DEG_W:0]    rnd;
  logic [DEG_W-1:0]  deg_d, deg_q;
  logic              undef_d, undef_q;
  rasp_flags_t       f1_q;

  always_comb begin
    if (flags_i.x_zero || z_i[ANG_W-1]) begin
      t = ANG_ZERO;
    end else if (z_i > signed'(ANG_90)) begin
      t = ANG_90;
    end else begin
      t = z_i;
    end
    // negative angles already wrapped by 360
    if (!flags_i.y_neg) begin
      if (!flags_i.x_neg) ang_d = t;
      else if (t == ANG_ZERO) ang_d = ANG_ZERO;
      else ang_d = ANG_360 - t;
    end else begin
      if (!flags_i.x_neg) ang_d = ANG_180 - t;
      else ang_d = t + ANG_180;
    end
  end

  always_comb begin
    rsum    = RND_W'(ang_q) + RND_HALF;
    rnd     = (DEG_W+1)'(rsum >> RND_SH);
    deg_d   = (rnd >= DEG_WRAP) ? DEG_ZERO : rnd[DEG_W-1:0];
    undef_d = 1'b0;
    if (f1_q.y_zero) begin
      if (f1_q.x_zero) begin
        undef_d = 1'b1;
        deg_d   = DEG_ZERO;
      end else begin
        deg_d = (!f1_q.x_neg != f1_q.up) ? DEG_90 : DEG_270;
      end
    end
  end

  assign rdy2       = ~v2_q | out_ready_i;
  assign rdy1       = ~v1_q | rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      ang_q <= ang_d;
      f1_q  <= flags_i;
    end
    if (rdy2 && v1_q) begin
      deg_q   <= deg_d;
      undef_q <= undef_d;
    end
  end

  assign out_valid_o = v2_q;
  assign deg_o       = deg_q;
  assign undef_o     = undef_q;

endmodule

FILE: hdl/raster_aspect_3x3.sv
// ----------------------------------------------------------------------------
// raster_aspect_3x3
// Terrain aspect of a 3x3 elevation window: Horn slopes, cross products with
// the cell spacings, CORDIC arctangent, fold to 0..360 degrees.
//
//  port group  dir  tdata (low bit first)                         tuser
//  s_axis      in   nw,nm,ne,cw,ce,sw,sm,se (s32 Q24.8), ew u32   -
//  m_axis      out  aspect_deg (u16 Q9.7)                         is_undefined
//  cfg         in   idx 0 up_flag (bit 0), idx 1 ns_spacing (u32) -
//
// One word per clock in and out while m_axis is ready; register stages: 2 slope,
// 4 multiply/normalize, one per CORDIC micro-rotation, 2 fold/round.
// Each stage holds while its successor is full; empty stages fill in, so a
// stall on m_axis loses or repeats nothing and bubbles close up.
// Reset clears all valid bits, up_flag to 0 and ns_spacing to 65536.
// ----------------------------------------------------------------------------
module raster_aspect_3x3
  import rasp_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // nw, nm, ne, cw, ce, sw, sm, se, ew_spacing
  input  logic [IN_W-1:0]       s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // aspect_deg
  output logic [DEG_W-1:0]      m_axis_tdata,
  // is_undefined
  output logic [0:0]            m_axis_tuser
);

  logic              up_q;
  logic [SPC_W-1:0]  ns_q;

  logic              sl_valid, sl_ready;
  logic [NUM_W-1:0]  sl_ax, sl_ay;
  logic [SPC_W-1:0]  sl_ew, sl_ns;
  rasp_flags_t       sl_flags;

  logic              mu_valid, mu_ready;
  logic [NORM_W-1:0] mu_px, mu_py;
  rasp_flags_t       mu_flags;

  logic                    co_valid, co_ready;
  logic signed [ANG_W-1:0] co_z;
  rasp_flags_t             co_flags;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q <= 1'b0;
      ns_q <= NS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UP_FLAG:    up_q <= cfg_data_i[0];
        REG_NS_SPACING: ns_q <= cfg_data_i[SPC_W-1:0];
        default:        ;
      endcase
    end
  end

  rasp_slope u_slope (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .ns_i        (ns_q),
    .up_i        (up_q),
    .out_valid_o (sl_valid),
    .out_ready_i (sl_ready),
    .ax_o        (sl_ax),
    .ay_o        (sl_ay),
    .ew_o        (sl_ew),
    .ns_o        (sl_ns),
    .flags_o     (sl_flags)
  );

  rasp_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sl_valid),
    .in_ready_o  (sl_ready),
    .ax_i        (sl_ax),
    .ay_i        (sl_ay),
    .ew_i        (sl_ew),
    .ns_i        (sl_ns),
    .flags_i     (sl_flags),
    .out_valid_o (mu_valid),
    .out_ready_i (mu_ready),
    .px_o        (mu_px),
    .py_o        (mu_py),
    .flags_o     (mu_flags)
  );

  rasp_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mu_valid),
    .in_ready_o  (mu_ready),
    .px_i        (mu_px),
    .py_i        (mu_py),
    .flags_i     (mu_flags),
    .out_valid_o (co_valid),
    .out_ready_i (co_ready),
    .z_o         (co_z),
    .flags_o     (co_flags)
  );

  rasp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (co_valid),
    .in_ready_o  (co_ready),
    .z_i         (co_z),
    .flags_i     (co_flags),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .deg_o       (m_axis_tdata),
    .undef_o     (m_axis_tuser[0])
  );

endmodule
